FILE: src/lrut_pkg.sv
// ----------------------------------------------------------------------------
// lrut_pkg
// Shared sizes and helpers for the LRU handle table.
// ----------------------------------------------------------------------------
package lrut_pkg;

	localparam int SLOTS  = 16;
	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int KEY_W  = 64;
	localparam int SLOT_W = 4;
	localparam int CAP_W  = 5;
	localparam int CMP_W  = 8;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(SLOTS - 1);

	localparam logic CMD_ACCESS = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	// zero acts as one, above SLOTS acts as SLOTS
	function automatic logic [CMP_W-1:0] cap_eff(input logic [CAP_W-1:0] cap);
		logic [CMP_W-1:0] c;
		c = CMP_W'(cap);
		if (c == '0)
			return CMP_W'(1);
		else if (c > CMP_W'(SLOTS))
			return CMP_W'(SLOTS);
		else
			return c;
	endfunction

endpackage

FILE: src/lru_handle_table.sv
// ----------------------------------------------------------------------------
// lru_handle_table
// Keyed table with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, command, key): command 0 looks up key,
// command 1 flushes the table. Output channel (out_valid/out_ready, hit,
// slot, evicted_valid, evicted_key, last): one or more results per input,
// last marks the final one. Config channel (cfg_valid/cfg_ready, capacity)
// sets the fill level at which a miss starts evicting; write it while idle.
// One input is processed at a time; in_ready is high only when idle.
// A single slot pointer walks the table, one slot per cycle, with one key
// comparator. A hit ends the walk at the matching slot; a miss walks every
// slot for the lookup, then searches from slot zero for rank zero for each
// eviction, then for a free slot. A flush runs one rank-zero search per entry.
// Results sit in an output register; when the receiver stalls with a result
// held, the walk pauses until that transfer completes.
// Reset empties the table and sets capacity to 16.
// ----------------------------------------------------------------------------
module lru_handle_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lrut_pkg::CAP_W-1:0]     capacity,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           command,
	input  logic [lrut_pkg::KEY_W-1:0]     key,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           hit,
	output logic [lrut_pkg::SLOT_W-1:0]    slot,
	output logic                           evicted_valid,
	output logic [lrut_pkg::KEY_W-1:0]     evicted_key,
	output logic                           last
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_EVICT = 3'd2;
	localparam logic [2:0] ST_FREE  = 3'd3;

	logic [2:0]                     state_q;
	logic [lrut_pkg::IDX_W-1:0]     idx_q;
	logic                           cmd_q;
	logic [lrut_pkg::KEY_W-1:0]     req_key_q;
	logic                           pend_q;
	logic [lrut_pkg::KEY_W-1:0]     pend_key_q;
	logic [lrut_pkg::CAP_W-1:0]     cap_q;
	logic [lrut_pkg::CNT_W-1:0]     count_q;
	logic [lrut_pkg::SLOTS-1:0]     valid_q;
	logic [lrut_pkg::IDX_W-1:0]     rank_q [lrut_pkg::SLOTS];
	logic [lrut_pkg::KEY_W-1:0]     key_q  [lrut_pkg::SLOTS];

	logic                           out_valid_q;
	logic                           hit_q;
	logic [lrut_pkg::SLOT_W-1:0]    slot_q;
	logic                           ev_valid_q;
	logic [lrut_pkg::KEY_W-1:0]     ev_key_q;
	logic                           last_q;

	logic                           cur_valid;
	logic [lrut_pkg::KEY_W-1:0]     cur_key;
	logic [lrut_pkg::IDX_W-1:0]     cur_rank;
	logic                           space;
	logic                           at_last;
	logic [lrut_pkg::IDX_W-1:0]     idx_next;
	logic [lrut_pkg::CMP_W-1:0]     cap_w;
	logic [lrut_pkg::CMP_W-1:0]     count_w;
	logic [lrut_pkg::CMP_W-1:0]     count_dec_w;
	logic                           do_hit;
	logic                           do_evict;
	logic                           do_insert;
	logic                           do_empty;
	logic                           do_out;
	logic                           evict_more;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign slot          = slot_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_key   = ev_key_q;
	assign last          = last_q;

	always_comb begin
		cur_valid   = valid_q[idx_q];
		cur_key     = key_q[idx_q];
		cur_rank    = rank_q[idx_q];
		space       = !out_valid_q || out_ready;
		at_last     = (idx_q == lrut_pkg::IDX_LAST);
		idx_next    = at_last ? '0 : idx_q + 1'b1;
		cap_w       = lrut_pkg::cap_eff(cap_q);
		count_w     = lrut_pkg::CMP_W'(count_q);
		count_dec_w = count_w - 1'b1;
		evict_more  = (count_dec_w >= cap_w);
		do_hit      = (state_q == ST_SCAN) && cur_valid && (cur_key == req_key_q) && space;
		do_evict    = (state_q == ST_EVICT) && cur_valid && (cur_rank == '0) && space;
		do_empty    = (state_q == ST_EVICT) && (cmd_q == lrut_pkg::CMD_FLUSH) &&
		              (count_q == '0) && space;
		do_insert   = (state_q == ST_FREE) && !cur_valid && space;
		do_out      = do_hit || do_empty || do_insert ||
		              (do_evict && ((cmd_q == lrut_pkg::CMD_FLUSH) || evict_more));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			cmd_q       <= lrut_pkg::CMD_ACCESS;
			pend_q      <= 1'b0;
			cap_q       <= lrut_pkg::CAP_RESET;
			count_q     <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < lrut_pkg::SLOTS; j++)
				rank_q[j] <= '0;
		end else begin
			if (cfg_valid)
				cap_q <= capacity;
			if (do_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q     <= command;
						req_key_q <= key;
						pend_q    <= 1'b0;
						idx_q     <= '0;
						state_q   <= (command == lrut_pkg::CMD_FLUSH) ? ST_EVICT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (do_hit) begin
						for (int j = 0; j < lrut_pkg::SLOTS; j++)
							if (valid_q[j] && rank_q[j] > cur_rank)
								rank_q[j] <= rank_q[j] - 1'b1;
						rank_q[idx_q] <= lrut_pkg::IDX_W'(count_q - 1'b1);
						hit_q         <= 1'b1;
						slot_q        <= lrut_pkg::SLOT_W'(idx_q);
						ev_valid_q    <= 1'b0;
						ev_key_q      <= '0;
						last_q        <= 1'b1;
						state_q       <= ST_IDLE;
					end else if (!(cur_valid && cur_key == req_key_q)) begin
						idx_q <= idx_next;
						if (at_last)
							state_q <= (count_w >= cap_w) ? ST_EVICT : ST_FREE;
					end
				end
				ST_EVICT: begin
					if (do_empty) begin
						hit_q       <= 1'b0;
						slot_q      <= '0;
						ev_valid_q  <= 1'b0;
						ev_key_q    <= '0;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end else if (do_evict) begin
						for (int j = 0; j < lrut_pkg::SLOTS; j++)
							if (valid_q[j] && rank_q[j] != '0)
								rank_q[j] <= rank_q[j] - 1'b1;
						valid_q[idx_q] <= 1'b0;
						count_q        <= count_q - 1'b1;
						idx_q          <= '0;
						if (cmd_q == lrut_pkg::CMD_FLUSH) begin
							hit_q       <= 1'b0;
							slot_q      <= lrut_pkg::SLOT_W'(idx_q);
							ev_valid_q  <= 1'b1;
							ev_key_q    <= cur_key;
							last_q      <= (count_q == lrut_pkg::CNT_W'(1));
							if (count_q == lrut_pkg::CNT_W'(1))
								state_q <= ST_IDLE;
						end else if (evict_more) begin
							hit_q       <= 1'b0;
							slot_q      <= lrut_pkg::SLOT_W'(idx_q);
							ev_valid_q  <= 1'b1;
							ev_key_q    <= cur_key;
							last_q      <= 1'b0;
						end else begin
							// final eviction rides on the insert result
							pend_q     <= 1'b1;
							pend_key_q <= cur_key;
							state_q    <= ST_FREE;
						end
					end else if (!(cur_valid && cur_rank == '0) && count_q != '0) begin
						idx_q <= idx_next;
					end
				end
				ST_FREE: begin
					if (do_insert) begin
						valid_q[idx_q] <= 1'b1;
						key_q[idx_q]   <= req_key_q;
						rank_q[idx_q]  <= lrut_pkg::IDX_W'(count_q);
						count_q        <= count_q + 1'b1;
						hit_q          <= 1'b0;
						slot_q         <= lrut_pkg::SLOT_W'(idx_q);
						ev_valid_q     <= pend_q;
						ev_key_q       <= pend_q ? pend_key_q : '0;
						last_q         <= 1'b1;
						state_q        <= ST_IDLE;
					end else if (cur_valid) begin
						idx_q <= idx_next;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: tb/tb_lru_handle_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_handle_table
// Self-checking bench for the LRU handle table. A scoreboard keeps its own
// copy of the table (keys, dense recency ranks, fill level, capacity) and
// predicts every result of each accepted access or flush. Results are checked
// in order, field by field. Stimulus starts with a directed pass over empty
// flush, hits, capacity cut below the fill level and out-of-range capacity,
// then random phases over a small key pool under several capacity settings,
// with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------

typedef struct {
	logic                        hit;
	logic [lrut_pkg::SLOT_W-1:0] slot;
	logic                        evicted_valid;
	logic [lrut_pkg::KEY_W-1:0]  evicted_key;
	logic                        last;
} lru_result_t;

class lru_scoreboard;
	logic                        slot_used[lrut_pkg::SLOTS];
	logic [lrut_pkg::KEY_W-1:0]  slot_key[lrut_pkg::SLOTS];
	logic [lrut_pkg::IDX_W-1:0]  slot_rank[lrut_pkg::SLOTS];
	logic [lrut_pkg::CNT_W-1:0]  fill;
	logic [lrut_pkg::CAP_W-1:0]  cap_reg;
	lru_result_t                 expected_q[$];
	int                          errors;

	function new();
		for (int i = 0; i < lrut_pkg::SLOTS; i++) begin
			slot_used[i] = 1'b0;
			slot_key[i]  = '0;
			slot_rank[i] = '0;
		end
		fill    = '0;
		cap_reg = lrut_pkg::CAP_RESET;
		errors  = 0;
	endfunction

	function void set_capacity(input logic [lrut_pkg::CAP_W-1:0] v);
		cap_reg = v;
	endfunction

	function int unsigned outstanding();
		return expected_q.size();
	endfunction

	function void push_result(input logic h, input int s, input logic ev,
			input logic [lrut_pkg::KEY_W-1:0] evk, input logic lst);
		lru_result_t r;
		r.hit           = h;
		r.slot          = lrut_pkg::SLOT_W'(s);
		r.evicted_valid = ev;
		r.evicted_key   = ev ? evk : '0;
		r.last          = lst;
		expected_q.push_back(r);
	endfunction

	// drop the least recent entry; 0 when the table is empty
	function bit evict_oldest(output int victim,
			output logic [lrut_pkg::KEY_W-1:0] vkey);
		victim = -1;
		vkey   = '0;
		for (int i = 0; i < lrut_pkg::SLOTS; i++)
			if (slot_used[i] && (victim < 0 || slot_rank[i] < slot_rank[victim]))
				victim = i;
		if (victim < 0)
			return 1'b0;
		vkey = slot_key[victim];
		slot_used[victim] = 1'b0;
		for (int j = 0; j < lrut_pkg::SLOTS; j++)
			if (slot_used[j] && slot_rank[j] > slot_rank[victim])
				slot_rank[j]--;
		slot_rank[victim] = '0;
		if (fill > 0)
			fill--;
		return 1'b1;
	endfunction

	function void note_input(input logic cmd, input logic [lrut_pkg::KEY_W-1:0] k);
		int                          victim;
		logic [lrut_pkg::KEY_W-1:0]  vkey;
		bit                          pend;
		int                          pend_slot;
		logic [lrut_pkg::KEY_W-1:0]  pend_key;
		int                          ce;
		int                          free_slot;
		logic [lrut_pkg::IDX_W-1:0]  r;

		pend      = 1'b0;
		pend_slot = 0;
		pend_key  = '0;
		if (cmd == lrut_pkg::CMD_FLUSH) begin
			while (evict_oldest(victim, vkey)) begin
				if (pend)
					push_result(1'b0, pend_slot, 1'b1, pend_key, 1'b0);
				pend      = 1'b1;
				pend_slot = victim;
				pend_key  = vkey;
			end
			if (pend)
				push_result(1'b0, pend_slot, 1'b1, pend_key, 1'b1);
			else
				push_result(1'b0, 0, 1'b0, '0, 1'b1);
			return;
		end

		for (int i = 0; i < lrut_pkg::SLOTS; i++) begin
			if (slot_used[i] && slot_key[i] == k) begin
				r = slot_rank[i];
				for (int j = 0; j < lrut_pkg::SLOTS; j++)
					if (slot_used[j] && slot_rank[j] > r)
						slot_rank[j]--;
				slot_rank[i] = (fill > 0) ? lrut_pkg::IDX_W'(fill - 1) : '0;
				push_result(1'b1, i, 1'b0, '0, 1'b1);
				return;
			end
		end

		ce = int'(cap_reg);
		if (ce == 0)
			ce = 1;
		if (ce > lrut_pkg::SLOTS)
			ce = lrut_pkg::SLOTS;
		while (int'(fill) >= ce) begin
			if (!evict_oldest(victim, vkey)) begin
				fill = '0;
				break;
			end
			if (pend)
				push_result(1'b0, pend_slot, 1'b1, pend_key, 1'b0);
			pend      = 1'b1;
			pend_slot = victim;
			pend_key  = vkey;
		end
		free_slot = 0;
		for (int i = lrut_pkg::SLOTS - 1; i >= 0; i--)
			if (!slot_used[i])
				free_slot = i;
		slot_used[free_slot] = 1'b1;
		slot_key[free_slot]  = k;
		slot_rank[free_slot] = lrut_pkg::IDX_W'(fill);
		fill++;
		push_result(1'b0, free_slot, pend, pend_key, 1'b1);
	endfunction

	function void check_result(input logic h, input logic [lrut_pkg::SLOT_W-1:0] s,
			input logic ev, input logic [lrut_pkg::KEY_W-1:0] evk, input logic lst);
		lru_result_t e;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected result hit=%b slot=%0d ev=%b evkey=%h last=%b",
				$time, h, s, ev, evk, lst);
			errors++;
			return;
		end
		e = expected_q.pop_front();
		if (h !== e.hit) begin
			$display("%0t: hit mismatch: expected %b, actual %b", $time, e.hit, h);
			errors++;
		end
		if (s !== e.slot) begin
			$display("%0t: slot mismatch: expected %0d, actual %0d", $time, e.slot, s);
			errors++;
		end
		if (ev !== e.evicted_valid) begin
			$display("%0t: evicted_valid mismatch: expected %b, actual %b",
				$time, e.evicted_valid, ev);
			errors++;
		end
		if (evk !== e.evicted_key) begin
			$display("%0t: evicted_key mismatch: expected %h, actual %h",
				$time, e.evicted_key, evk);
			errors++;
		end
		if (lst !== e.last) begin
			$display("%0t: last mismatch: expected %b, actual %b", $time, e.last, lst);
			errors++;
		end
	endfunction
endclass

module tb_lru_handle_table;

	localparam int SETTLE_CYCLES = 2 * lrut_pkg::SLOTS + 8;
	localparam int POOL_SIZE     = 24;
	localparam int PHASE_ITEMS   = 19;
	localparam int NUM_PHASES    = 6;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [lrut_pkg::CAP_W-1:0]  capacity;
	logic                        in_valid;
	logic                        in_ready;
	logic                        command;
	logic [lrut_pkg::KEY_W-1:0]  key;
	logic                        out_valid;
	logic                        out_ready;
	logic                        hit;
	logic [lrut_pkg::SLOT_W-1:0] slot;
	logic                        evicted_valid;
	logic [lrut_pkg::KEY_W-1:0]  evicted_key;
	logic                        last;

	lru_scoreboard               sb;
	bit                          busy_send;
	bit                          busy_recv;
	logic [lrut_pkg::KEY_W-1:0]  key_pool[POOL_SIZE];

	lru_handle_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.capacity      (capacity),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.key           (key),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hit           (hit),
		.slot          (slot),
		.evicted_valid (evicted_valid),
		.evicted_key   (evicted_key),
		.last          (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic logic [lrut_pkg::KEY_W-1:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_item(input logic cmd, input logic [lrut_pkg::KEY_W-1:0] k);
		int gap;
		gap = busy_send ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		key      <= k;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_input(cmd, k);
		@(negedge clk);
	endtask

	task automatic write_capacity(input logic [lrut_pkg::CAP_W-1:0] v);
		cfg_valid <= 1'b1;
		capacity  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_capacity(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = busy_recv ? $urandom_range(0, 19) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			sb.check_result(hit, slot, evicted_valid, evicted_key, last);
		end
	end

	initial begin
		logic [lrut_pkg::KEY_W-1:0] k;
		logic [lrut_pkg::CAP_W-1:0] cap_plan[NUM_PHASES];
		int                         pick;

		sb        = new();
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		capacity  = lrut_pkg::CAP_RESET;
		in_valid  = 1'b0;
		command   = lrut_pkg::CMD_ACCESS;
		key       = '0;
		busy_send = 1'b1;
		busy_recv = 1'b1;
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = rand_key();
		key_pool[0] = '0;
		key_pool[1] = '1;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty flush, extreme keys, hit, capacity cut below fill
		send_item(lrut_pkg::CMD_FLUSH, '0);
		send_item(lrut_pkg::CMD_ACCESS, '0);
		send_item(lrut_pkg::CMD_ACCESS, '1);
		send_item(lrut_pkg::CMD_ACCESS, '0);
		for (int i = 0; i < 5; i++)
			send_item(lrut_pkg::CMD_ACCESS, rand_key());
		wait_idle();
		write_capacity(lrut_pkg::CAP_W'(2));
		k = rand_key();
		send_item(lrut_pkg::CMD_ACCESS, k);
		send_item(lrut_pkg::CMD_ACCESS, k);
		wait_idle();
		write_capacity('0);
		k = rand_key();
		send_item(lrut_pkg::CMD_ACCESS, k);
		send_item(lrut_pkg::CMD_ACCESS, k);
		wait_idle();
		write_capacity('1);
		for (int i = 0; i < 3; i++)
			send_item(lrut_pkg::CMD_ACCESS, rand_key());
		send_item(lrut_pkg::CMD_ACCESS, '0);
		send_item(lrut_pkg::CMD_FLUSH, '1);
		wait_idle();

		// random phases; capacity 16 is followed by a cut down to one
		cap_plan[0] = lrut_pkg::CAP_RESET;
		cap_plan[1] = lrut_pkg::CAP_W'(1);
		cap_plan[2] = '1;
		cap_plan[3] = '0;
		cap_plan[4] = lrut_pkg::CAP_W'($urandom_range(2, lrut_pkg::SLOTS - 1));
		cap_plan[5] = lrut_pkg::CAP_W'($urandom_range(lrut_pkg::SLOTS + 1, 30));
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_capacity(cap_plan[p]);
			busy_send = ($urandom_range(0, 3) != 0);
			busy_recv = ($urandom_range(0, 3) != 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 6)
					send_item(lrut_pkg::CMD_FLUSH, rand_key());
				else if (pick < 78)
					send_item(lrut_pkg::CMD_ACCESS,
						key_pool[$urandom_range(0, POOL_SIZE - 1)]);
				else
					send_item(lrut_pkg::CMD_ACCESS, rand_key());
			end
			wait_idle();
		end

		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
